[rtl/abd_pkg.sv]
// abd_pkg: control word layout, microprogram rom and filter coefficients
// for the beat detector sequencer; no dependencies
`default_nettype none

package abd_pkg;

  localparam int unsigned STEP_W  = 4;
  localparam int unsigned COEF_W  = 20;
  localparam logic [STEP_W-1:0] UC_LAST = 4'd10;

  // multiplier operand a
  typedef enum logic [2:0] {
    A_X, A_BO0, A_BO1, A_MAG, A_EO, A_TO0, A_TO1
  } a_sel_e;

  // coefficient select, signed q1.18
  typedef enum logic [2:0] {
    C_BASS_IN, C_BASS_Y2, C_BASS_Y1, C_ENV_IN, C_ENV_Y1,
    C_BEAT_IN, C_BEAT_Y2, C_BEAT_Y1
  } c_sel_e;

  // accumulator operand
  typedef enum logic [1:0] {
    B_M, B_NBIN0, B_EIN, B_NTIN0
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_BASS, WR_ENV, WR_BEAT
  } wr_e;

  typedef enum logic [1:0] {
    CTL_NEXT, CTL_END_NDEC, CTL_END
  } ctl_e;

  typedef struct packed {
    logic    mul_en;
    logic    shift;
    a_sel_e  a_sel;
    c_sel_e  c_sel;
    acc_op_e acc_op;
    b_sel_e  b_sel;
    logic    tmp_wr;
    wr_e     wr;
    ctl_e    ctl;
  } ucode_t;

  function automatic logic signed [COEF_W-1:0] coef(input c_sel_e sel);
    logic signed [COEF_W-1:0] c;
    case (sel)
      C_BASS_IN: c = 20'sd28807;
      C_BASS_Y2: c = -20'sd208668;
      C_BASS_Y1: c = 20'sd469320;
      C_ENV_IN:  c = 20'sd1638;
      C_ENV_Y1:  c = 20'sd258870;
      C_BEAT_IN: c = 20'sd37369;
      C_BEAT_Y2: c = -20'sd187954;
      C_BEAT_Y1: c = 20'sd378894;
      default:   c = '0;
    endcase
    return c;
  endfunction

  // microprogram: bass band-pass, envelope, then beat band-pass on decimated steps
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t u;
    u = '{mul_en: 1'b0, shift: 1'b0, a_sel: A_X, c_sel: C_BASS_IN,
          acc_op: ACC_HOLD, b_sel: B_M, tmp_wr: 1'b0, wr: WR_NONE, ctl: CTL_END};
    case (step)
      4'd0: begin
        u.mul_en = 1'b1; u.shift = 1'b1; u.a_sel = A_X; u.c_sel = C_BASS_IN;
        u.acc_op = ACC_LOAD; u.b_sel = B_NBIN0; u.ctl = CTL_NEXT;
      end
      4'd1: begin
        u.mul_en = 1'b1; u.a_sel = A_BO0; u.c_sel = C_BASS_Y2;
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.tmp_wr = 1'b1; u.ctl = CTL_NEXT;
      end
      4'd2: begin
        u.mul_en = 1'b1; u.a_sel = A_BO1; u.c_sel = C_BASS_Y1;
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.ctl = CTL_NEXT;
      end
      4'd3: begin
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.wr = WR_BASS; u.ctl = CTL_NEXT;
      end
      4'd4: begin
        u.mul_en = 1'b1; u.a_sel = A_MAG; u.c_sel = C_ENV_IN;
        u.acc_op = ACC_LOAD; u.b_sel = B_EIN; u.ctl = CTL_NEXT;
      end
      4'd5: begin
        u.mul_en = 1'b1; u.a_sel = A_EO; u.c_sel = C_ENV_Y1;
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.tmp_wr = 1'b1; u.ctl = CTL_NEXT;
      end
      4'd6: begin
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.wr = WR_ENV; u.ctl = CTL_END_NDEC;
      end
      4'd7: begin
        u.mul_en = 1'b1; u.a_sel = A_EO; u.c_sel = C_BEAT_IN;
        u.acc_op = ACC_LOAD; u.b_sel = B_NTIN0; u.ctl = CTL_NEXT;
      end
      4'd8: begin
        u.mul_en = 1'b1; u.a_sel = A_TO0; u.c_sel = C_BEAT_Y2;
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.tmp_wr = 1'b1; u.ctl = CTL_NEXT;
      end
      4'd9: begin
        u.mul_en = 1'b1; u.a_sel = A_TO1; u.c_sel = C_BEAT_Y1;
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.ctl = CTL_NEXT;
      end
      4'd10: begin
        u.acc_op = ACC_ADD; u.b_sel = B_M; u.wr = WR_BEAT; u.ctl = CTL_END;
      end
      default: begin
        u.ctl = CTL_END;
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/audio_beat_detector.sv]
// audio_beat_detector: bass band-pass, envelope and beat band-pass filters
// run by a microcoded sequencer over one shared multiplier; uses abd_pkg
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | sink      | in_valid_i / in_stall_o | adc_sample_i
//  out     | source    | out_valid_o / out_stall_i | beat_found_o, beat_level_o,
//          |           |                        | interval_samples_o
//  cfg     | sink      | cfg_we_i               | cfg_idx_i, cfg_data_i
//
//  a sample is accepted while idle, then 7 microcode steps run
//  (bass filter and envelope, the rom steps through the shared multiplier)
//  a decimated sample runs 4 more steps for the beat filter
//  the final step holds while the output register is full and stalled
//  reset clears filter history, counters and sequencer; config regs take defaults

module audio_beat_detector #(
  parameter int unsigned ADC_BITS = 10
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [ADC_BITS-1:0] adc_sample_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic                beat_found_o,
  output logic signed [31:0]  beat_level_o,
  output logic [15:0]         interval_samples_o,
  input  wire                 cfg_we_i,
  input  wire  [1:0]          cfg_idx_i,
  input  wire  [15:0]         cfg_data_i
);

  // centered sample width: wider of adc code and offset, plus sign
  localparam int unsigned XW = ((ADC_BITS > 10) ? ADC_BITS : 10) + 1;
  localparam int unsigned PW = 32 + abd_pkg::COEF_W + 16;
  localparam int unsigned AW = 36;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_REFR   = 2'd2;
  localparam logic [1:0] REG_DECIM  = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // configuration registers
  logic [9:0]  offset_q, decim_cfg_q;
  logic [15:0] thresh_q, refr_q;

  // sequencer
  logic                      busy_q;
  logic [abd_pkg::STEP_W-1:0] step_q;
  abd_pkg::ucode_t           uc;
  logic                      go;

  // datapath
  logic signed [XW-1:0] x_q;
  logic signed [PW-1:0] p_q, p_d;
  logic signed [AW-1:0] acc_q, acc_d, acc_opnd;
  logic signed [31:0]   tmp_q;
  logic signed [31:0]   m_val, acc_sat, mag, mul_a;
  logic signed [PW-1:0] rnd;
  logic signed [31:0]   bin0_q, bin1_q, bo0_q, bo1_q;
  logic signed [31:0]   ein_q, eo_q;
  logic signed [31:0]   tin0_q, tin1_q, to0_q, to1_q;
  logic [9:0]           decim_cnt_q;
  logic [10:0]          cnt_next;
  logic                 is_dec;
  logic [15:0]          since_q, since_inc, last_int_q;
  logic                 found;
  logic signed [31:0]   thr_q16;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_full;

  assign uc       = abd_pkg::ucode_rom(step_q);
  assign out_full = out_valid_q && out_stall_i;
  assign go       = busy_q && !((uc.ctl == abd_pkg::CTL_END) && out_full);

  // result stays while stalled, a new one loads from the final step
  assign out_valid_d = out_full || (go && (uc.ctl == abd_pkg::CTL_END));

  assign in_stall_o = busy_q;

  // multiplier operand a
  assign mag = (bo1_q == S32_MIN) ? S32_MAX : (bo1_q[31] ? -bo1_q : bo1_q);

  always_comb begin
    case (uc.a_sel)
      abd_pkg::A_X:   mul_a = {{(32-XW){x_q[XW-1]}}, x_q};
      abd_pkg::A_BO0: mul_a = bo0_q;
      abd_pkg::A_BO1: mul_a = bo1_q;
      abd_pkg::A_MAG: mul_a = mag;
      abd_pkg::A_EO:  mul_a = eo_q;
      abd_pkg::A_TO0: mul_a = to0_q;
      abd_pkg::A_TO1: mul_a = to1_q;
      default:        mul_a = '0;
    endcase
  end

  // product; the input scaling step takes the sample as an integer, so shift to q.16
  always_comb begin
    logic signed [31+abd_pkg::COEF_W:0] prod;
    prod = mul_a * abd_pkg::coef(uc.c_sel);
    if (uc.shift) begin
      p_d = {prod, 16'b0};
    end else begin
      p_d = {{16{prod[31+abd_pkg::COEF_W]}}, prod};
    end
  end

  // round half up to q.16 and saturate
  assign rnd = (p_q + PW'(131072)) >>> 18;
  always_comb begin
    if (&rnd[PW-1:31] || ~|rnd[PW-1:31]) begin
      m_val = rnd[31:0];
    end else begin
      m_val = rnd[PW-1] ? S32_MIN : S32_MAX;
    end
  end

  // accumulator
  always_comb begin
    case (uc.b_sel)
      abd_pkg::B_M:     acc_opnd = {{(AW-32){m_val[31]}}, m_val};
      abd_pkg::B_NBIN0: acc_opnd = -{{(AW-32){bin0_q[31]}}, bin0_q};
      abd_pkg::B_EIN:   acc_opnd = {{(AW-32){ein_q[31]}}, ein_q};
      abd_pkg::B_NTIN0: acc_opnd = -{{(AW-32){tin0_q[31]}}, tin0_q};
      default:          acc_opnd = '0;
    endcase
    case (uc.acc_op)
      abd_pkg::ACC_LOAD: acc_d = acc_opnd;
      abd_pkg::ACC_ADD:  acc_d = acc_q + acc_opnd;
      default:           acc_d = acc_q;
    endcase
  end

  always_comb begin
    if (&acc_d[AW-1:31] || ~|acc_d[AW-1:31]) begin
      acc_sat = acc_d[31:0];
    end else begin
      acc_sat = acc_d[AW-1] ? S32_MIN : S32_MAX;
    end
  end

  // sample counters and beat decision
  assign since_inc = (since_q == 16'hffff) ? since_q : since_q + 16'd1;
  assign cnt_next  = {1'b0, decim_cnt_q} + 11'd1;
  assign is_dec    = !(cnt_next < {1'b0, decim_cfg_q});
  assign thr_q16   = {8'b0, thresh_q, 8'b0};
  assign found     = (acc_sat > thr_q16) && (since_q > refr_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= 10'd503;
      thresh_q    <= 16'd2621;
      refr_q      <= 16'd1400;
      decim_cfg_q <= 10'd200;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET: offset_q    <= cfg_data_i[9:0];
        REG_THRESH: thresh_q    <= cfg_data_i;
        REG_REFR:   refr_q      <= cfg_data_i;
        REG_DECIM:  decim_cfg_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (!busy_q) begin
        if (in_valid_i) begin
          busy_q <= 1'b1;
          step_q <= '0;
        end
      end else if (go) begin
        case (uc.ctl)
          abd_pkg::CTL_NEXT: step_q <= step_q + abd_pkg::STEP_W'(1);
          abd_pkg::CTL_END_NDEC: begin
            if (is_dec) begin
              step_q <= step_q + abd_pkg::STEP_W'(1);
            end else begin
              busy_q <= 1'b0;
            end
          end
          default: begin
            busy_q <= 1'b0;
          end
        endcase
      end
    end
  end

  // centered sample capture
  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      x_q <= $signed(XW'(adc_sample_i)) - $signed(XW'(offset_q));
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (go && uc.mul_en) begin
      p_q <= p_d;
    end
    if (go) begin
      acc_q <= acc_d;
    end
    if (go && uc.tmp_wr) begin
      tmp_q <= m_val;
    end
    if (go && (uc.wr == abd_pkg::WR_BEAT)) begin
      beat_found_o <= found;
      beat_level_o <= acc_sat;
      interval_samples_o <= found ? since_q : last_int_q;
    end
  end

  // filter history and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin0_q <= '0; bin1_q <= '0; bo0_q <= '0; bo1_q <= '0;
      ein_q  <= '0; eo_q   <= '0;
      tin0_q <= '0; tin1_q <= '0; to0_q <= '0; to1_q <= '0;
      decim_cnt_q <= '0;
      since_q     <= '0;
      last_int_q  <= '0;
    end else if (go) begin
      case (uc.wr)
        abd_pkg::WR_BASS: begin
          bin0_q <= bin1_q;
          bin1_q <= tmp_q;
          bo0_q  <= bo1_q;
          bo1_q  <= acc_sat;
        end
        abd_pkg::WR_ENV: begin
          ein_q   <= tmp_q;
          eo_q    <= acc_sat;
          since_q <= since_inc;
          decim_cnt_q <= is_dec ? 10'd0 : cnt_next[9:0];
        end
        abd_pkg::WR_BEAT: begin
          tin0_q <= tin1_q;
          tin1_q <= tmp_q;
          to0_q  <= to1_q;
          to1_q  <= acc_sat;
          if (found) begin
            last_int_q <= since_q;
            since_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  // an accepted sample starts the program at its first step
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (busy_q && step_q == '0))
    else $error("sequencer did not start on accepted sample");

  // the step counter never runs past the last rom word
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= abd_pkg::UC_LAST))
    else $error("step counter out of program");

  // a new result appears only from the final beat filter step
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |->
      ($past(busy_q) && $past(step_q) == abd_pkg::UC_LAST))
    else $error("result emitted outside the beat step");

  // a flagged beat always carries a nonzero interval
  a_interval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && beat_found_o) |-> (interval_samples_o != 16'd0))
    else $error("beat with zero interval");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking bench for audio_beat_detector with its own fixed point
// model of the bass, envelope and beat filters; needs abd_pkg and the rtl top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // register map of the config port
  typedef enum logic [1:0] {
    REG_CENTER, REG_THRESH, REG_REFRACT, REG_DECIM
  } reg_idx_e;

  // one decimated report of the detector
  typedef struct packed {
    logic               found;
    logic signed [31:0] level;
    logic [15:0]        interval;
  } report_t;

  // directed plan: register write, plain sample, or sample with a typed report
  typedef enum logic [1:0] {
    ROW_CFG, ROW_SAMPLE, ROW_CHECKED
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    reg_idx_e  idx;
    logic [15:0] data;
    report_t   rep;
  } row_t;

  localparam int PLAN_LEN    = 30;
  localparam int SETTLE      = 16;    // room for a decimated sample in flight
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int WATCHDOG    = 2000;  // cycles with no handshake at all

  // filter coefficients, signed q1.18
  localparam logic signed [31:0] K_BASS_IN = 32'sd28807;
  localparam logic signed [31:0] K_BASS_Y2 = -32'sd208668;
  localparam logic signed [31:0] K_BASS_Y1 = 32'sd469320;
  localparam logic signed [31:0] K_ENV_IN  = 32'sd1638;
  localparam logic signed [31:0] K_ENV_Y1  = 32'sd258870;
  localparam logic signed [31:0] K_BEAT_IN = 32'sd37369;
  localparam logic signed [31:0] K_BEAT_Y2 = -32'sd187954;
  localparam logic signed [31:0] K_BEAT_Y1 = 32'sd378894;

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [9:0]         adc_sample_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic               beat_found_o;
  logic signed [31:0] beat_level_o;
  logic [15:0]        interval_samples_o;
  logic               cfg_we_i     = 1'b0;
  logic [1:0]         cfg_idx_i    = '0;
  logic [15:0]        cfg_data_i   = '0;

  audio_beat_detector #(
    .ADC_BITS(10)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .beat_found_o       (beat_found_o),
    .beat_level_o       (beat_level_o),
    .interval_samples_o (interval_samples_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // detector model: own copy of config and filter history
  // ---------------------------------------------------------------------------
  logic [9:0]         center_q;
  logic [15:0]        thresh_q;
  logic [15:0]        refract_q;
  logic [9:0]         decim_q;
  logic signed [31:0] bass_x [2];   // index 0 is two samples back
  logic signed [31:0] bass_y [2];
  logic signed [31:0] env_x, env_y;
  logic signed [31:0] beat_x [2];
  logic signed [31:0] beat_y [2];
  logic [9:0]         decim_cnt;
  logic [15:0]        since_beat;
  logic [15:0]        last_gap;

  report_t report_q [$];     // reports still owed by the block
  int      fault_count = 0;

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // q.16 value times q1.18 coefficient, round half up back to q.16
  function automatic logic signed [31:0] fx_mul(input logic signed [63:0] v,
                                                input logic signed [31:0] k);
    logic signed [63:0] p;
    p = v * k + 64'sd131072;
    return clip32(p >>> 18);
  endfunction

  // second order band-pass: y = x - x[n-2] + c2*y[n-2] + c1*y[n-1]
  function automatic logic signed [31:0] band_pass(
    input logic signed [31:0] xin, input logic signed [31:0] x2,
    input logic signed [31:0] y2, input logic signed [31:0] y1,
    input logic signed [31:0] c2, input logic signed [31:0] c1);
    logic signed [63:0] acc;
    acc = xin;
    acc = acc - x2 + fx_mul(y2, c2) + fx_mul(y1, c1);
    return clip32(acc);
  endfunction

  task automatic model_reset();
    center_q   = 10'd503;
    thresh_q   = 16'd2621;
    refract_q  = 16'd1400;
    decim_q    = 10'd200;
    bass_x     = '{32'sd0, 32'sd0};
    bass_y     = '{32'sd0, 32'sd0};
    beat_x     = '{32'sd0, 32'sd0};
    beat_y     = '{32'sd0, 32'sd0};
    env_x      = '0;
    env_y      = '0;
    decim_cnt  = '0;
    since_beat = '0;
    last_gap   = '0;
  endtask

  task automatic model_write(input reg_idx_e idx, input logic [15:0] d);
    case (idx)
      REG_CENTER:  center_q  = d[9:0];
      REG_THRESH:  thresh_q  = d;
      REG_REFRACT: refract_q = d;
      REG_DECIM:   decim_q   = d[9:0];
      default: ;
    endcase
  endtask

  // one microphone sample through the chain; made is set on decimated steps
  task automatic step_detector(input logic [9:0] code, output bit made,
                               output report_t rep);
    logic signed [63:0] x, acc, thr16, lvl64;
    logic signed [31:0] xin, bass, mag, envin, env, beatin, level;
    logic [10:0]        cnt;
    x = 64'(code);
    x = x - 64'(center_q);
    xin  = fx_mul(x * 64'sd65536, K_BASS_IN);
    bass = band_pass(xin, bass_x[0], bass_y[0], bass_y[1], K_BASS_Y2, K_BASS_Y1);
    bass_x[0] = bass_x[1];
    bass_x[1] = xin;
    bass_y[0] = bass_y[1];
    bass_y[1] = bass;

    // magnitude, the most negative value saturates
    if (bass == 32'sh80000000) mag = 32'sh7fffffff;
    else if (bass < 0) mag = -bass;
    else mag = bass;

    envin = fx_mul(mag, K_ENV_IN);
    acc = env_x;
    acc = acc + envin + fx_mul(env_y, K_ENV_Y1);
    env = clip32(acc);
    env_x = envin;
    env_y = env;

    if (since_beat != 16'hffff) since_beat = since_beat + 16'd1;

    made = 1'b0;
    rep  = '0;
    cnt = {1'b0, decim_cnt} + 11'd1;
    if (cnt < {1'b0, decim_q}) begin
      decim_cnt = cnt[9:0];
      return;
    end
    decim_cnt = '0;

    beatin = fx_mul(env, K_BEAT_IN);
    level  = band_pass(beatin, beat_x[0], beat_y[0], beat_y[1], K_BEAT_Y2, K_BEAT_Y1);
    beat_x[0] = beat_x[1];
    beat_x[1] = beatin;
    beat_y[0] = beat_y[1];
    beat_y[1] = level;

    // threshold is q8.8, level is q15.16
    thr16 = 64'(thresh_q) << 8;
    lvl64 = level;
    made = 1'b1;
    if (lvl64 > thr16 && since_beat > refract_q) begin
      rep.found  = 1'b1;
      last_gap   = since_beat;
      since_beat = '0;
    end
    rep.level    = level;
    rep.interval = last_gap;
  endtask

  // ---------------------------------------------------------------------------
  // monitors, all sampling at the rising edge
  // ---------------------------------------------------------------------------
  logic    row_typed = 1'b0;   // current sample carries a typed report
  report_t row_rep   = '0;

  // every accepted sample advances the model
  always @(posedge clk_i) begin : take_sample
    bit      made;
    report_t rep;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      step_detector(adc_sample_i, made, rep);
      if (made) report_q.push_back(row_typed ? row_rep : rep);
    end
  end

  // every accepted report is checked against the oldest one owed
  always @(posedge clk_i) begin : check_report
    report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report found=%0b level=%0d interval=%0d", $time,
                 beat_found_o, beat_level_o, interval_samples_o);
        fault_count++;
      end else begin
        want = report_q.pop_front();
        if (beat_found_o !== want.found) begin
          $display("%0t: beat_found expected %0b got %0b", $time, want.found,
                   beat_found_o);
          fault_count++;
        end
        if (beat_level_o !== want.level) begin
          $display("%0t: beat_level expected %0d got %0d", $time, want.level,
                   beat_level_o);
          fault_count++;
        end
        if (interval_samples_o !== want.interval) begin
          $display("%0t: interval_samples expected %0d got %0d", $time,
                   want.interval, interval_samples_o);
          fault_count++;
        end
      end
    end
  end

  // watchdog: a stuck handshake ends the run
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall patterns in stretches, one long hold-off on request
  // ---------------------------------------------------------------------------
  bit squeeze_go   = 1'b0;
  bit squeeze_done = 1'b0;

  initial begin : rx_pattern
    int mode, span, period;
    @(posedge rst_ni);
    forever begin
      if (squeeze_go && !squeeze_done) begin
        // hold long enough for the output register and the input to back up
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        squeeze_done = 1'b1;
      end
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(10, 150);
      period = $urandom_range(2, 5);
      for (int n = 0; n < span; n++) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i = 1'b0;                              // free running
          1: out_stall_i = 1'($urandom_range(0, 1));          // coin toss
          2: out_stall_i = (n % period) != 0;                 // regular
          default: out_stall_i = $urandom_range(0, 4) != 0;   // mostly held
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender: bursts with gaps, config writes only while idle
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // called at a falling edge, returns at a falling edge once accepted
  task automatic send_sample(input logic [9:0] code, input bit typed,
                             input report_t rep);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = 150;          // long stretch with no gaps
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   = 1'b1;
    adc_sample_i = code;
    row_typed    = typed;
    row_rep      = rep;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drop valid, let every owed report arrive, then cover a sample in flight
  task automatic settle();
    in_valid_i = 1'b0;
    row_typed  = 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] d);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = d;
    @(posedge clk_i);
    model_write(idx, d);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // audio-like codes: bass tone bursts around the center, quiet stretches, noise
  int tone_left = 0, tone_kind = 0, tone_half = 1, tone_amp = 0, tone_pos = 0;

  task automatic synth_code(input int ctr, output logic [9:0] code);
    int v;
    if (tone_left == 0) begin
      tone_kind = $urandom_range(0, 7);
      tone_half = $urandom_range(1, 24);
      tone_amp  = $urandom_range(0, 520);
      tone_left = $urandom_range(8, 80);
      tone_pos  = 0;
    end
    tone_left--;
    tone_pos++;
    case (tone_kind)
      0: v = $urandom_range(0, 1023);                       // plain noise
      1: v = ctr + $urandom_range(0, 6) - 3;                // near silence
      default: begin
        v = ((tone_pos / tone_half) % 2) ? ctr + tone_amp : ctr - tone_amp;
        v = v + $urandom_range(0, 16) - 8;
      end
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    code = v[9:0];
  endtask

  // one setting of all four registers, then n audio samples
  task automatic run_phase(input logic [9:0] dec, input logic [15:0] thr,
                           input logic [15:0] refr, input logic [9:0] ctr,
                           input int n, input bit squeeze);
    logic [9:0] code;
    settle();
    // upper data bits above the 10 bit registers are junk on purpose
    write_reg(REG_CENTER, {6'($urandom), ctr});
    write_reg(REG_THRESH, thr);
    write_reg(REG_REFRACT, refr);
    write_reg(REG_DECIM, {6'($urandom), dec});
    if (squeeze) squeeze_go = 1'b1;
    for (int i = 0; i < n; i++) begin
      synth_code(ctr, code);
      send_sample(code, 1'b0, '0);
    end
  endtask

  function automatic row_t cfg_row(input reg_idx_e idx, input logic [15:0] d);
    return '{kind: ROW_CFG, idx: idx, data: d, rep: '0};
  endfunction

  function automatic row_t smp_row(input logic [9:0] code);
    return '{kind: ROW_SAMPLE, idx: REG_CENTER, data: {6'd0, code}, rep: '0};
  endfunction

  function automatic row_t chk_row(input logic [9:0] code, input report_t rep);
    return '{kind: ROW_CHECKED, idx: REG_CENTER, data: {6'd0, code}, rep: rep};
  endfunction

  row_t plan [PLAN_LEN];

  initial begin : stimulus
    logic [15:0] thr, refr;
    logic [9:0]  ctr;
    model_reset();

    plan = '{
      // every sample is decimated, no threshold, no refractory
      cfg_row(REG_DECIM, 16'd1),
      cfg_row(REG_THRESH, 16'd0),
      cfg_row(REG_REFRACT, 16'd0),
      // centered code out of reset: all filters stay at zero, level 0 is no beat
      chk_row(10'd503, '{found: 1'b0, level: 32'sd0, interval: 16'd0}),
      chk_row(10'd503, '{found: 1'b0, level: 32'sd0, interval: 16'd0}),
      // full swing; the first beat counts its interval from reset
      smp_row(10'd1023),
      smp_row(10'd0),
      smp_row(10'd1023),
      smp_row(10'd0),
      smp_row(10'd512),
      // center at zero, with junk in the unused data bits
      cfg_row(REG_CENTER, 16'hfc00),
      smp_row(10'd0),
      smp_row(10'd1023),
      // center at top: most negative input
      cfg_row(REG_CENTER, 16'h03ff),
      smp_row(10'd0),
      smp_row(10'd0),
      // refractory at maximum: no beat can ever be accepted
      cfg_row(REG_REFRACT, 16'hffff),
      smp_row(10'd1023),
      smp_row(10'd0),
      smp_row(10'd1023),
      // threshold at maximum, decimation zero acts as one
      cfg_row(REG_THRESH, 16'hffff),
      cfg_row(REG_DECIM, 16'h0000),
      smp_row(10'd0),
      smp_row(10'd1023),
      smp_row(10'd341),
      smp_row(10'd682),
      // decimation 3, upper data bits set
      cfg_row(REG_DECIM, 16'hfc03),
      smp_row(10'd1023),
      smp_row(10'd0),
      smp_row(10'd1023)
    };

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_sample(plan[i].data[9:0], plan[i].kind == ROW_CHECKED, plan[i].rep);
      end
    end

    // a report every sample while the receiver holds off for a long time
    run_phase(10'd1, 16'd256, 16'd4, 10'd503, 120, 1'b1);

    // random settings with short decimation so reports come often
    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 3))
        0: thr = 16'd0;
        1: thr = 16'($urandom_range(0, 64));
        2: thr = 16'($urandom_range(0, 3000));
        default: thr = 16'($urandom_range(0, 65535));
      endcase
      refr = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 80));
      ctr  = ($urandom_range(0, 1) == 0) ? 10'd503 : 10'($urandom_range(0, 1023));
      run_phase(10'($urandom_range(1, 12)), thr, refr, ctr, $urandom_range(70, 90), 1'b0);
    end

    // longest decimation; the counter runs all the way up
    run_phase(10'd1023, 16'd0, 16'd0, 10'd1023, 1024, 1'b0);

    // back to defaults-like operation with a fast rate
    run_phase(10'd2, 16'd2621, 16'd1400, 10'd503, 60, 1'b0);

    // drain: nothing owed, then room for a late extra report
    in_valid_i = 1'b0;
    while (report_q.size() != 0) @(negedge clk_i);
    repeat (2 * SETTLE) @(negedge clk_i);
    if (fault_count == 0 && report_q.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

[files.f]
rtl/abd_pkg.sv
rtl/audio_beat_detector.sv
tb/sv/tb_top.sv
